// File: hw/rtl/uirb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UART interrupt ring buffers package
// Shared widths, operation codes and the ring status bundle.
// ----------------------------------------------------------------------------
package uirb_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned FILL_W          = 8;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned RING_DEPTH_DEF  = 256;
  localparam int unsigned FILL_MAX        = 255;

  localparam logic [OP_W-1:0] OP_HOST_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_HOST_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SERVICE    = 2'd2;

  typedef struct packed {
    logic full;
    logic empty;
    logic full_nxt;
    logic empty_nxt;
  } ring_stat_t;

endpackage : uirb_pkg
`default_nettype wire

// File: hw/rtl/uirb_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UART interrupt ring buffers: one byte ring
// Byte memory with read and write pointers, one slot left unused. The pop
// data is registered and holds until the next pop.
// ----------------------------------------------------------------------------
module uirb_ring #(
  parameter int unsigned RING_DEPTH = uirb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [uirb_pkg::BYTE_W-1:0] push_data,
  input  wire logic                        pop,
  output logic      [uirb_pkg::BYTE_W-1:0] pop_data,
  output uirb_pkg::ring_stat_t             stat,
  output logic      [uirb_pkg::FILL_W-1:0] fill
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(RING_DEPTH);

  logic [uirb_pkg::BYTE_W-1:0] mem [RING_DEPTH];
  logic [uirb_pkg::BYTE_W-1:0] pop_data_r;
  logic [PTR_W-1:0]            rd_ptr_r;
  logic [PTR_W-1:0]            rd_ptr_nxt;
  logic [PTR_W-1:0]            wr_ptr_r;
  logic [PTR_W-1:0]            wr_ptr_nxt;
  logic [PTR_W-1:0]            wr_inc;
  logic [PTR_W-1:0]            wr_inc_nxt;
  logic [CNT_W-1:0]            count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_inc     = ptr_inc(wr_ptr_r);
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    wr_ptr_nxt = push ? wr_inc : wr_ptr_r;
    wr_inc_nxt = ptr_inc(wr_ptr_nxt);

    stat.full      = (wr_inc == rd_ptr_r);
    stat.empty     = (wr_ptr_r == rd_ptr_r);
    stat.full_nxt  = (wr_inc_nxt == rd_ptr_nxt);
    stat.empty_nxt = (wr_ptr_nxt == rd_ptr_nxt);

    if (wr_ptr_r >= rd_ptr_r) begin
      count = CNT_W'(wr_ptr_r) - CNT_W'(rd_ptr_r);
    end else begin
      count = CNT_W'(wr_ptr_r) + DEPTH_C - CNT_W'(rd_ptr_r);
    end
    if (32'(count) > uirb_pkg::FILL_MAX) begin
      fill = uirb_pkg::FILL_W'(uirb_pkg::FILL_MAX);
    end else begin
      fill = uirb_pkg::FILL_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      pop_data_r <= mem[rd_ptr_r];
    end
  end

  assign pop_data = pop_data_r;

endmodule : uirb_ring
`default_nettype wire

// File: hw/rtl/uart_irq_ring_buffers_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UART interrupt ring buffers, top level
// Transmit and receive byte rings with interrupt enables, driven by host
// writes, host reads and interrupt service beats.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle while in_stall is low and gives
// exactly one result beat for each. On acceptance the pointers are updated
// and the ring memory access issued; when the beat moves on from the first
// stage, the output registers pick up the registered memory read data.
// Each ring is a byte memory with a write and a read port, RING_DEPTH entries
// holding at most RING_DEPTH-1 bytes, empty out of reset with no clearing pass.
module uart_irq_ring_buffers_top #(
  parameter int unsigned RING_DEPTH = uirb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [uirb_pkg::OP_W-1:0]   in_op,
  input  wire logic [uirb_pkg::BYTE_W-1:0] in_host_byte,
  input  wire logic                        in_tx_empty_flag,
  input  wire logic                        in_rx_valid_flag,
  input  wire logic [uirb_pkg::BYTE_W-1:0] in_line_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_accepted,
  output logic      [uirb_pkg::BYTE_W-1:0] out_read_byte,
  output logic                             out_tx_strobe,
  output logic      [uirb_pkg::BYTE_W-1:0] out_tx_byte,
  output logic                             out_rx_dropped,
  output logic                             out_rx_irq_enable,
  output logic                             out_tx_irq_enable,
  output logic      [uirb_pkg::FILL_W-1:0] out_tx_fill,
  output logic      [uirb_pkg::FILL_W-1:0] out_rx_fill
);

  uirb_pkg::ring_stat_t        tx_stat;
  uirb_pkg::ring_stat_t        rx_stat;
  logic [uirb_pkg::BYTE_W-1:0] tx_pop_data;
  logic [uirb_pkg::BYTE_W-1:0] rx_pop_data;
  logic [uirb_pkg::FILL_W-1:0] tx_fill;
  logic [uirb_pkg::FILL_W-1:0] rx_fill;

  logic in_accept;
  logic out_free;
  logic s1_move;
  logic tx_push;
  logic tx_pop;
  logic rx_push;
  logic rx_pop;
  logic accepted;
  logic dropped;

  logic       rx_en_r;
  logic       rx_en_nxt;
  logic       tx_en_r;
  logic       tx_en_nxt;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic       s1_accepted_r;
  logic       s1_read_r;
  logic       s1_strobe_r;
  logic       s1_dropped_r;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_accepted_r;
  logic [uirb_pkg::BYTE_W-1:0] out_read_byte_r;
  logic                        out_tx_strobe_r;
  logic [uirb_pkg::BYTE_W-1:0] out_tx_byte_r;
  logic                        out_rx_dropped_r;
  logic                        out_rx_en_r;
  logic                        out_tx_en_r;
  logic [uirb_pkg::FILL_W-1:0] out_tx_fill_r;
  logic [uirb_pkg::FILL_W-1:0] out_rx_fill_r;

  uirb_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tx_push),
    .push_data (in_host_byte),
    .pop       (tx_pop),
    .pop_data  (tx_pop_data),
    .stat      (tx_stat),
    .fill      (tx_fill)
  );

  uirb_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rx_push),
    .push_data (in_line_byte),
    .pop       (rx_pop),
    .pop_data  (rx_pop_data),
    .stat      (rx_stat),
    .fill      (rx_fill)
  );

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    s1_move   = s1_valid_r && out_free;
    in_stall  = s1_valid_r && !s1_move;
    in_accept = in_valid && !in_stall;

    tx_push   = 1'b0;
    tx_pop    = 1'b0;
    rx_push   = 1'b0;
    rx_pop    = 1'b0;
    accepted  = 1'b0;
    dropped   = 1'b0;
    rx_en_nxt = rx_en_r;
    tx_en_nxt = tx_en_r;

    if (in_accept) begin
      unique case (in_op)
        uirb_pkg::OP_HOST_WRITE: begin
          tx_push  = !tx_stat.full;
          accepted = !tx_stat.full;
          if (!tx_stat.full) begin
            tx_en_nxt = 1'b1;
          end
        end
        uirb_pkg::OP_HOST_READ: begin
          rx_pop    = !rx_stat.empty;
          accepted  = !rx_stat.empty;
          rx_en_nxt = 1'b1;
        end
        uirb_pkg::OP_SERVICE: begin
          if (in_tx_empty_flag) begin
            tx_pop = !tx_stat.empty;
          end else if (in_rx_valid_flag) begin
            rx_push = !rx_stat.full;
            dropped = rx_stat.full;
          end
        end
        default: begin
        end
      endcase
      if (in_op == uirb_pkg::OP_SERVICE) begin
        rx_en_nxt = !rx_stat.full_nxt;
        tx_en_nxt = !tx_stat.empty_nxt;
      end
    end

    s1_valid_nxt  = in_accept || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_en_r     <= 1'b0;
      tx_en_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_en_r     <= rx_en_nxt;
      tx_en_r     <= tx_en_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_accepted_r <= accepted;
      s1_read_r     <= rx_pop;
      s1_strobe_r   <= tx_pop;
      s1_dropped_r  <= dropped;
    end
    if (s1_move) begin
      out_accepted_r   <= s1_accepted_r;
      out_read_byte_r  <= s1_read_r ? rx_pop_data : '0;
      out_tx_strobe_r  <= s1_strobe_r;
      out_tx_byte_r    <= s1_strobe_r ? tx_pop_data : '0;
      out_rx_dropped_r <= s1_dropped_r;
      out_rx_en_r      <= rx_en_r;
      out_tx_en_r      <= tx_en_r;
      out_tx_fill_r    <= tx_fill;
      out_rx_fill_r    <= rx_fill;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_read_byte     = out_read_byte_r;
  assign out_tx_strobe     = out_tx_strobe_r;
  assign out_tx_byte       = out_tx_byte_r;
  assign out_rx_dropped    = out_rx_dropped_r;
  assign out_rx_irq_enable = out_rx_en_r;
  assign out_tx_irq_enable = out_tx_en_r;
  assign out_tx_fill       = out_tx_fill_r;
  assign out_rx_fill       = out_rx_fill_r;

endmodule : uart_irq_ring_buffers_top
`default_nettype wire

// File: test/tb_uart_irq_ring_buffers_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Testbench for the UART interrupt ring buffers
// Drives host writes, host reads, interrupt service beats and unused op codes
// through the input channel under random idling on both sides. A scoreboard
// mirrors both rings and the interrupt enables, predicts one result per
// accepted beat and checks every result field by field, in order.
// ----------------------------------------------------------------------------
module tb_uart_irq_ring_buffers_top;

  localparam int unsigned DEPTH    = uirb_pkg::RING_DEPTH_DEF;
  localparam int unsigned OP_W     = uirb_pkg::OP_W;
  localparam int unsigned BYTE_W   = uirb_pkg::BYTE_W;
  localparam int unsigned FILL_W   = uirb_pkg::FILL_W;
  localparam int unsigned FILL_MAX = uirb_pkg::FILL_MAX;
  localparam logic [OP_W-1:0] OP_HOST_WRITE = uirb_pkg::OP_HOST_WRITE;
  localparam logic [OP_W-1:0] OP_HOST_READ  = uirb_pkg::OP_HOST_READ;
  localparam logic [OP_W-1:0] OP_SERVICE    = uirb_pkg::OP_SERVICE;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] host_byte;
    logic              tx_flag;
    logic              rx_flag;
    logic [BYTE_W-1:0] line_byte;
  } uart_beat_t;

  typedef struct packed {
    logic              accepted;
    logic [BYTE_W-1:0] read_byte;
    logic              tx_strobe;
    logic [BYTE_W-1:0] tx_byte;
    logic              rx_dropped;
    logic              rx_irq_enable;
    logic              tx_irq_enable;
    logic [FILL_W-1:0] tx_fill;
    logic [FILL_W-1:0] rx_fill;
  } ring_result_t;

  typedef enum int {PH_FILL_TX, PH_DRAIN_TX, PH_FILL_RX, PH_DRAIN_RX, PH_MIXED} phase_t;

  class ring_mirror;
    logic [BYTE_W-1:0] tx_mem [DEPTH];
    logic [BYTE_W-1:0] rx_mem [DEPTH];
    int unsigned tx_rd, tx_wr, rx_rd, rx_wr;
    logic [1:0] enables;
    ring_result_t expected_results [$];
    int unsigned mismatches, results_seen;
    int unsigned n_wr_ok, n_wr_refused, n_rd_ok, n_rd_refused, n_sent, n_dropped;

    function new();
      tx_rd = 0;
      tx_wr = 0;
      rx_rd = 0;
      rx_wr = 0;
      enables = '0;
    endfunction

    function int unsigned advance(int unsigned p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function logic [FILL_W-1:0] level(int unsigned rd, int unsigned wr);
      int unsigned n;
      n = (wr >= rd) ? (wr - rd) : (wr + DEPTH - rd);
      return (n > FILL_MAX) ? FILL_MAX[FILL_W-1:0] : n[FILL_W-1:0];
    endfunction

    function void note_beat(uart_beat_t b);
      ring_result_t r;
      r = '0;
      case (b.op)
        OP_HOST_WRITE: begin
          if (advance(tx_wr) != tx_rd) begin
            tx_mem[tx_wr] = b.host_byte;
            tx_wr = advance(tx_wr);
            enables[1] = 1'b1;
            r.accepted = 1'b1;
            n_wr_ok++;
          end else begin
            n_wr_refused++;
          end
        end
        OP_HOST_READ: begin
          enables[0] = 1'b1;
          if (rx_rd != rx_wr) begin
            r.read_byte = rx_mem[rx_rd];
            rx_rd = advance(rx_rd);
            r.accepted = 1'b1;
            n_rd_ok++;
          end else begin
            n_rd_refused++;
          end
        end
        OP_SERVICE: begin
          if (b.tx_flag) begin
            if (tx_rd != tx_wr) begin
              r.tx_byte = tx_mem[tx_rd];
              r.tx_strobe = 1'b1;
              tx_rd = advance(tx_rd);
              n_sent++;
            end
          end else if (b.rx_flag) begin
            if (advance(rx_wr) != rx_rd) begin
              rx_mem[rx_wr] = b.line_byte;
              rx_wr = advance(rx_wr);
            end else begin
              r.rx_dropped = 1'b1;
              n_dropped++;
            end
          end
          enables[0] = (advance(rx_wr) != rx_rd);
          enables[1] = (tx_rd != tx_wr);
        end
        default: ;
      endcase
      r.rx_irq_enable = enables[0];
      r.tx_irq_enable = enables[1];
      r.tx_fill = level(tx_rd, tx_wr);
      r.rx_fill = level(rx_rd, rx_wr);
      expected_results.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                   results_seen, name, want, got);
      end
    endfunction

    function void check_beat(ring_result_t got);
      ring_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result beat with nothing outstanding: %p", got);
        return;
      end
      want = expected_results.pop_front();
      compare("accepted", 32'(want.accepted), 32'(got.accepted));
      compare("read_byte", 32'(want.read_byte), 32'(got.read_byte));
      compare("tx_strobe", 32'(want.tx_strobe), 32'(got.tx_strobe));
      compare("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
      compare("rx_dropped", 32'(want.rx_dropped), 32'(got.rx_dropped));
      compare("rx_irq_enable", 32'(want.rx_irq_enable), 32'(got.rx_irq_enable));
      compare("tx_irq_enable", 32'(want.tx_irq_enable), 32'(got.tx_irq_enable));
      compare("tx_fill", 32'(want.tx_fill), 32'(got.tx_fill));
      compare("rx_fill", 32'(want.rx_fill), 32'(got.rx_fill));
      results_seen++;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_op;
  logic [BYTE_W-1:0] in_host_byte;
  logic              in_tx_empty_flag;
  logic              in_rx_valid_flag;
  logic [BYTE_W-1:0] in_line_byte;
  logic              out_valid;
  logic              out_stall;
  logic              out_accepted;
  logic [BYTE_W-1:0] out_read_byte;
  logic              out_tx_strobe;
  logic [BYTE_W-1:0] out_tx_byte;
  logic              out_rx_dropped;
  logic              out_rx_irq_enable;
  logic              out_tx_irq_enable;
  logic [FILL_W-1:0] out_tx_fill;
  logic [FILL_W-1:0] out_rx_fill;

  ring_mirror  book;
  logic        idle_on;
  int unsigned beats_sent;
  int unsigned cycles;
  int unsigned stall_left;
  int unsigned tx_peak, rx_peak;

  uart_irq_ring_buffers_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_host_byte      (in_host_byte),
    .in_tx_empty_flag  (in_tx_empty_flag),
    .in_rx_valid_flag  (in_rx_valid_flag),
    .in_line_byte      (in_line_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_read_byte     (out_read_byte),
    .out_tx_strobe     (out_tx_strobe),
    .out_tx_byte       (out_tx_byte),
    .out_rx_dropped    (out_rx_dropped),
    .out_rx_irq_enable (out_rx_irq_enable),
    .out_tx_irq_enable (out_tx_irq_enable),
    .out_tx_fill       (out_tx_fill),
    .out_rx_fill       (out_rx_fill)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, book.outstanding());
      $display("tb_uart_irq_ring_buffers_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_beat('{out_accepted, out_read_byte, out_tx_strobe, out_tx_byte,
                        out_rx_dropped, out_rx_irq_enable, out_tx_irq_enable,
                        out_tx_fill, out_rx_fill});
      if (32'(out_tx_fill) > tx_peak) tx_peak = 32'(out_tx_fill);
      if (32'(out_rx_fill) > rx_peak) rx_peak = 32'(out_rx_fill);
    end
  end

  task automatic send_beat(uart_beat_t b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= b.op;
    in_host_byte     <= b.host_byte;
    in_tx_empty_flag <= b.tx_flag;
    in_rx_valid_flag <= b.rx_flag;
    in_line_byte     <= b.line_byte;
    do @(posedge clk); while (in_stall);
    book.note_beat(b);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.outstanding() != 0);
  endtask

  function automatic uart_beat_t make_beat(phase_t kind);
    uart_beat_t b;
    int unsigned roll;
    b.op        = OP_W'($urandom_range(0, 3));
    b.host_byte = BYTE_W'($urandom_range(0, 255));
    b.tx_flag   = 1'($urandom_range(0, 1));
    b.rx_flag   = 1'($urandom_range(0, 1));
    b.line_byte = BYTE_W'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    case (kind)
      PH_FILL_TX: begin
        if (roll < 90) b.op = OP_HOST_WRITE;
      end
      PH_DRAIN_TX: begin
        if (roll < 80) begin
          b.op = OP_SERVICE;
          b.tx_flag = 1'b1;
        end
      end
      PH_FILL_RX: begin
        if (roll < 90) begin
          b.op = OP_SERVICE;
          b.tx_flag = 1'b0;
          b.rx_flag = 1'b1;
        end
      end
      PH_DRAIN_RX: begin
        if (roll < 80) b.op = OP_HOST_READ;
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic run_phase(phase_t kind, int unsigned count);
    repeat (count) send_beat(make_beat(kind));
  endtask

  initial begin
    book             = new();
    rst_n            = 1'b0;
    idle_on          = 1'b0;
    in_valid         = 1'b0;
    in_op            = OP_HOST_WRITE;
    in_host_byte     = '0;
    in_tx_empty_flag = 1'b0;
    in_rx_valid_flag = 1'b0;
    in_line_byte     = '0;
    out_stall        = 1'b0;
    beats_sent       = 0;
    cycles           = 0;
    tx_peak          = 0;
    rx_peak          = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_beat('{OP_HOST_READ, 8'h00, 1'b0, 1'b0, 8'h00});
    send_beat('{OP_SERVICE, 8'h00, 1'b1, 1'b0, 8'h00});
    send_beat('{OP_SERVICE, 8'hff, 1'b0, 1'b0, 8'hff});
    send_beat('{OP_UNUSED, 8'hff, 1'b1, 1'b1, 8'hff});
    send_beat('{OP_HOST_WRITE, 8'h00, 1'b0, 1'b0, 8'h00});
    send_beat('{OP_HOST_WRITE, 8'hff, 1'b1, 1'b1, 8'hff});
    send_beat('{OP_HOST_WRITE, 8'ha5, 1'b0, 1'b0, 8'h5a});
    send_beat('{OP_SERVICE, 8'h00, 1'b1, 1'b1, 8'h77});
    send_beat('{OP_SERVICE, 8'h00, 1'b0, 1'b1, 8'hff});
    send_beat('{OP_SERVICE, 8'hff, 1'b0, 1'b1, 8'h00});
    send_beat('{OP_HOST_READ, 8'hff, 1'b1, 1'b1, 8'hff});
    send_beat('{OP_HOST_READ, 8'h00, 1'b0, 1'b0, 8'h00});
    send_beat('{OP_HOST_READ, 8'h00, 1'b0, 1'b0, 8'h00});
    send_beat('{OP_SERVICE, 8'h00, 1'b1, 1'b0, 8'h00});
    send_beat('{OP_SERVICE, 8'h00, 1'b1, 1'b1, 8'h11});
    send_beat('{OP_SERVICE, 8'h00, 1'b1, 1'b0, 8'h00});
    send_beat('{OP_UNUSED, 8'h00, 1'b0, 1'b0, 8'h00});

    idle_on = 1'b1;
    run_phase(PH_FILL_TX, 320);
    drain_results();
    run_phase(PH_FILL_RX, 320);
    while (beats_sent < 1050) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_phase(phase_t'($urandom_range(0, 4)), $urandom_range(20, 120));
    end
    idle_on = 1'b0;
    while (beats_sent < 1200)
      run_phase(phase_t'($urandom_range(0, 4)), $urandom_range(20, 60));

    drain_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d beats: %0d writes taken, %0d refused; %0d reads taken, %0d refused.",
             beats_sent, book.n_wr_ok, book.n_wr_refused, book.n_rd_ok, book.n_rd_refused);
    $display("%0d bytes transmitted, %0d received bytes dropped, peak fill tx %0d rx %0d.",
             book.n_sent, book.n_dropped, tx_peak, rx_peak);
    if (book.mismatches == 0 && book.outstanding() == 0) begin
      $display("tb_uart_irq_ring_buffers_top: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", book.mismatches, book.outstanding());
      $display("tb_uart_irq_ring_buffers_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
